### rtl/core/masked_median_combine_core_assert.svh
// assertion macros used by the checker file
`ifndef MASKED_MEDIAN_COMBINE_CORE_ASSERT_SVH
`define MASKED_MEDIAN_COMBINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define MMC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define MMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mmc_pkg.sv
package mmc_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SAMPLE_W    = 32;
    localparam int COUNT_W     = 4;
    localparam int RANK_W      = 3;
    localparam int MASK_OFFSET = NUM_SLOTS * SAMPLE_W;
    localparam int S_TDATA_W   = MASK_OFFSET + NUM_SLOTS;
    localparam int M_FIELDS_W  = SAMPLE_W + COUNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [NUM_SLOTS-1:0]     sample_vec_t;
    typedef logic [RANK_W-1:0]           rank_t;
    typedef rank_t [NUM_SLOTS-1:0]       rank_vec_t;
    typedef logic [NUM_SLOTS-1:0]        mask_t;
    typedef logic [COUNT_W-1:0]          count_t;

    // one ranked pixel column as it leaves the ranking stage
    typedef struct packed {
        sample_vec_t samples;
        rank_vec_t   ranks;
        mask_t       mask;
        count_t      count;
    } rank_stage_t;

endpackage

### rtl/core/mmc_rank.sv
module mmc_rank
    import mmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  sample_vec_t in_samples,
    input  mask_t       in_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output rank_stage_t out_stage
);

    logic        valid_reg;
    rank_stage_t stage_reg;
    rank_stage_t stage_next;

    // rank of a sample = valid samples strictly below it, ties broken by slot order
    always_comb begin
        logic [NUM_SLOTS-1:0] below;
        stage_next.samples = in_samples;
        stage_next.mask    = in_mask;
        stage_next.count   = COUNT_W'($countones(in_mask));
        for (int i = 0; i < NUM_SLOTS; i++) begin
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (j == i) begin
                    below[j] = 1'b0;
                end else if (j < i) begin
                    below[j] = in_mask[j] &&
                               ($signed(in_samples[j]) <= $signed(in_samples[i]));
                end else begin
                    below[j] = in_mask[j] &&
                               ($signed(in_samples[j]) < $signed(in_samples[i]));
                end
            end
            stage_next.ranks[i] = RANK_W'($countones(below));
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

endmodule

### rtl/core/mmc_select.sv
module mmc_select
    import mmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rank_stage_t in_stage,
    output logic        out_valid,
    input  logic        out_ready,
    output sample_t     out_median,
    output count_t      out_count
);

    logic    valid_reg;
    sample_t median_reg;
    sample_t median_next;
    count_t  count_reg;

    always_comb begin
        rank_t                 mid_hi;
        rank_t                 mid_lo;
        logic [SAMPLE_W-1:0]   hi_val;
        logic [SAMPLE_W-1:0]   lo_val;
        logic signed [SAMPLE_W:0] pair_sum;
        mid_hi = RANK_W'(in_stage.count >> 1);
        mid_lo = mid_hi - RANK_W'(1);
        hi_val = '0;
        lo_val = '0;
        // ranks of valid samples are distinct, so an or of the matches is a mux
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (in_stage.mask[i] && in_stage.ranks[i] == mid_hi) begin
                hi_val = hi_val | in_stage.samples[i];
            end
            if (in_stage.mask[i] && in_stage.ranks[i] == mid_lo) begin
                lo_val = lo_val | in_stage.samples[i];
            end
        end
        pair_sum = $signed({hi_val[SAMPLE_W-1], hi_val}) +
                   $signed({lo_val[SAMPLE_W-1], lo_val});
        if (in_stage.count == '0) begin
            median_next = '0;
        end else if (in_stage.count[0]) begin
            median_next = hi_val;
        end else begin
            // floor of the half sum is the sum without its lsb
            median_next = pair_sum[SAMPLE_W:1];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_median = median_reg;
    assign out_count  = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            median_reg <= median_next;
            count_reg  <= in_stage.count;
        end
    end

endmodule

### rtl/core/masked_median_combine_core.sv
// channel   dir  tdata (low bit up)                              bits
// s_axis    in   sample_0 .. sample_7 (32 each), valid_mask (8)  264
// m_axis    out  median_value (32), valid_count (4), zero pad    40
//
// three register stages: input, ranking, selection; one beat per cycle unless m_axis stalls
// a result beat passes the input, ranking and selection registers in turn before it shows on m_axis
// the 8x8 rank compare sets the ranking stage
// each stage holds its beat while the next cannot take it, bubbles are squeezed out
// aresetn is synchronous; it clears the stage valid flags only
module masked_median_combine_core
    import mmc_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample_0 .. sample_7, valid_mask
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // median_value, valid_count, zero pad
);

    // mask bits of images past STACK_DEPTH are dropped
    localparam logic [NUM_SLOTS:0]   ONE_W    = (NUM_SLOTS + 1)'(1);
    localparam logic [NUM_SLOTS:0]   USE_WIDE = (ONE_W << STACK_DEPTH) - ONE_W;
    localparam logic [NUM_SLOTS-1:0] USE_MASK = USE_WIDE[NUM_SLOTS-1:0];

    logic        in_valid_reg;
    sample_vec_t in_samples_reg;
    mask_t       in_mask_reg;
    sample_vec_t samples_next;
    mask_t       mask_next;
    logic        in_ready;
    logic        rank_ready;
    logic        rank_valid;
    rank_stage_t rank_stage;
    logic        sel_ready;
    sample_t     median;
    count_t      count;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            samples_next[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
        end
        mask_next = s_tdata[MASK_OFFSET +: NUM_SLOTS] & USE_MASK;
    end

    assign in_ready = !in_valid_reg || rank_ready;
    assign s_tready = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_samples_reg <= samples_next;
            in_mask_reg    <= mask_next;
        end
    end

    mmc_rank u_rank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_ready   (rank_ready),
        .in_samples (in_samples_reg),
        .in_mask    (in_mask_reg),
        .out_valid  (rank_valid),
        .out_ready  (sel_ready),
        .out_stage  (rank_stage)
    );

    mmc_select u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rank_valid),
        .in_ready   (sel_ready),
        .in_stage   (rank_stage),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (median),
        .out_count  (count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, count, median};

endmodule

### rtl/core/mmc_checker.sv
`include "masked_median_combine_core_assert.svh"

module mmc_checker
    import mmc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `MMC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `MMC_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[35:32] <= 4'd8, "valid_count above stack depth")
    `MMC_ASSERT_NOW(a_empty_zero, m_tvalid && m_tdata[35:32] == 4'd0, m_tdata[31:0] == 32'd0, "median nonzero with no valid sample")
    `MMC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:36] == 4'd0, "tdata pad bits not zero")

endmodule

bind masked_median_combine_core mmc_checker u_mmc_checker (.*);
